// ===== sv/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the point-in-polygon-with-slack block.
// ----------------------------------------------------------------------------
package pip_pkg;

  // Slack register: unsigned fixed point, same fraction bits as coordinates
  localparam int SLACK_BITS = 15;
  localparam logic [SLACK_BITS-1:0] SLACK_RESET = 15'd32;

  // Squared slack limit held in the decide stage
  localparam int LIM_BITS = 2 * SLACK_BITS;
  localparam logic [LIM_BITS-1:0] LIM_RESET = 30'd1024;

  // Vertex count saturates here; below COUNT_MIN the polygon is too small
  localparam logic [1:0] COUNT_SAT = 2'd3;
  localparam logic [1:0] COUNT_MIN = 2'd2;

  // Per-beat control flags carried down the pipeline
  typedef struct packed {
    logic last;      // final vertex of the polygon
    logic has_prev;  // an edge from a previous vertex exists
    logic few;       // polygon ends with fewer than three vertices
  } ctl_t;

  // Edge straddle / direction flags from the product stage
  typedef struct packed {
    logic str_e;     // edge prev->cur straddles the ray line
    logic pos_e;     // edge prev->cur goes upward
    logic str_c;     // closing edge cur->first straddles the ray line
    logic pos_c;     // closing edge goes upward
  } edge_t;

endpackage

// ===== sv/pip_if.sv =====
// ----------------------------------------------------------------------------
// pip interfaces
// Valid/ready channels for vertex beats, result beats and slack writes.
// ----------------------------------------------------------------------------
interface pip_vtx_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic                         last_vertex;

  modport source (output valid, point_x, point_y, vertex_x, vertex_y, last_vertex,
                  input ready);
  modport sink   (input valid, point_x, point_y, vertex_x, vertex_y, last_vertex,
                  output ready);
endinterface

interface pip_res_if;
  logic valid;
  logic ready;
  logic accepted;
  logic inside_res;
  logic near_vertex;
  logic too_few;

  modport source (output valid, accepted, inside_res, near_vertex, too_few,
                  input ready);
  modport sink   (input valid, accepted, inside_res, near_vertex, too_few,
                  output ready);
endinterface

interface pip_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pip_pkg::SLACK_BITS-1:0]  slack;

  modport source (output valid, slack, input ready);
  modport sink   (input valid, slack, output ready);
endinterface

// ===== sv/pip_track.sv =====
// ----------------------------------------------------------------------------
// pip_track
// Input stage: accepts vertex beats, tracks first/previous vertex and the
// vertex count of the open polygon, and registers each beat with its edge.
// ----------------------------------------------------------------------------
module pip_track #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  pip_vtx_if.sink                      vtx,
  output logic                         s1_valid,
  input  logic                         s1_ready,
  output logic signed [COORD_BITS-1:0] px,
  output logic signed [COORD_BITS-1:0] py,
  output logic signed [COORD_BITS-1:0] vx,
  output logic signed [COORD_BITS-1:0] vy,
  output logic signed [COORD_BITS-1:0] ax,
  output logic signed [COORD_BITS-1:0] ay,
  output logic signed [COORD_BITS-1:0] fx,
  output logic signed [COORD_BITS-1:0] fy,
  output pip_pkg::ctl_t                ctl
);

  logic [1:0]                  count;
  logic signed [COORD_BITS-1:0] prev_x, prev_y, first_x, first_y;
  logic                        take;

  assign vtx.ready = !s1_valid || s1_ready;
  assign take      = vtx.valid && vtx.ready;

  // Stage valid and polygon vertex count
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      count    <= '0;
    end else begin
      if (vtx.ready) begin
        s1_valid <= vtx.valid;
      end
      if (take) begin
        if (vtx.last_vertex) begin
          count <= '0;
        end else if (count != pip_pkg::COUNT_SAT) begin
          count <= count + 2'd1;
        end
      end
    end
  end

  // Beat payload plus first/previous vertex of the polygon
  always_ff @(posedge clk) begin
    if (take) begin
      px <= vtx.point_x;
      py <= vtx.point_y;
      vx <= vtx.vertex_x;
      vy <= vtx.vertex_y;
      if (count == '0) begin
        ax      <= vtx.vertex_x;
        ay      <= vtx.vertex_y;
        fx      <= vtx.vertex_x;
        fy      <= vtx.vertex_y;
        first_x <= vtx.vertex_x;
        first_y <= vtx.vertex_y;
      end else begin
        ax <= prev_x;
        ay <= prev_y;
        fx <= first_x;
        fy <= first_y;
      end
      prev_x       <= vtx.vertex_x;
      prev_y       <= vtx.vertex_y;
      ctl.last     <= vtx.last_vertex;
      ctl.has_prev <= (count != '0);
      ctl.few      <= (count < pip_pkg::COUNT_MIN);
    end
  end

endmodule

// ===== sv/pip_geom.sv =====
// ----------------------------------------------------------------------------
// pip_geom
// Product stage: cross-multiplication terms for the current edge and the
// closing edge, plus the squared vertex distance terms, all exact width.
// ----------------------------------------------------------------------------
module pip_geom #(
  parameter int COORD_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s1_valid,
  output logic                             s1_ready,
  input  logic signed [COORD_BITS-1:0]     px,
  input  logic signed [COORD_BITS-1:0]     py,
  input  logic signed [COORD_BITS-1:0]     vx,
  input  logic signed [COORD_BITS-1:0]     vy,
  input  logic signed [COORD_BITS-1:0]     ax,
  input  logic signed [COORD_BITS-1:0]     ay,
  input  logic signed [COORD_BITS-1:0]     fx,
  input  logic signed [COORD_BITS-1:0]     fy,
  input  pip_pkg::ctl_t                    ctl_in,
  output logic                             s2_valid,
  input  logic                             s2_ready,
  output logic signed [2*COORD_BITS+1:0]   lhs_e,
  output logic signed [2*COORD_BITS+1:0]   rhs_e,
  output logic signed [2*COORD_BITS+1:0]   lhs_c,
  output logic signed [2*COORD_BITS+1:0]   rhs_c,
  output logic signed [2*COORD_BITS+1:0]   sq_x,
  output logic signed [2*COORD_BITS+1:0]   sq_y,
  output pip_pkg::edge_t                   edges,
  output pip_pkg::ctl_t                    ctl_out
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 2;

  logic signed [DW-1:0] d_e, u_e, w_e, t_e;
  logic signed [DW-1:0] d_c, u_c, w_c, t_c;
  logic signed [DW-1:0] dx, dy;
  logic                 above_p, above_a, above_f;
  pip_pkg::edge_t       edges_next;

  assign s1_ready = !s2_valid || s2_ready;

  // Edge prev->cur: (px-ax)*(vy-ay) against (vx-ax)*(py-ay)
  assign d_e = DW'(vy) - DW'(ay);
  assign u_e = DW'(px) - DW'(ax);
  assign w_e = DW'(vx) - DW'(ax);
  assign t_e = DW'(py) - DW'(ay);

  // Closing edge cur->first
  assign d_c = DW'(fy) - DW'(vy);
  assign u_c = DW'(px) - DW'(vx);
  assign w_c = DW'(fx) - DW'(vx);
  assign t_c = DW'(py) - DW'(vy);

  // Vertex offset from the query point
  assign dx = DW'(vx) - DW'(px);
  assign dy = DW'(vy) - DW'(py);

  // Straddle tests against the ray line y = py
  assign above_a = (ay > py);
  assign above_p = (vy > py);
  assign above_f = (fy > py);

  always_comb begin
    edges_next.str_e = (above_a != above_p);
    edges_next.pos_e = (d_e > 0);
    edges_next.str_c = (above_p != above_f);
    edges_next.pos_c = (d_c > 0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_ready) begin
      s2_valid <= s1_valid;
    end
  end

  // Product registers
  always_ff @(posedge clk) begin
    if (s1_valid && s1_ready) begin
      lhs_e   <= PW'(u_e) * PW'(d_e);
      rhs_e   <= PW'(w_e) * PW'(t_e);
      lhs_c   <= PW'(u_c) * PW'(d_c);
      rhs_c   <= PW'(w_c) * PW'(t_c);
      sq_x    <= PW'(dx) * PW'(dx);
      sq_y    <= PW'(dy) * PW'(dy);
      edges   <= edges_next;
      ctl_out <= ctl_in;
    end
  end

endmodule

// ===== sv/pip_decide.sv =====
// ----------------------------------------------------------------------------
// pip_decide
// Final stage: crossing compares, slack compare, parity and near state, and
// the result register. Also holds the squared slack limit.
// ----------------------------------------------------------------------------
module pip_decide #(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  pip_cfg_if.sink                        cfg,
  input  logic                           s2_valid,
  output logic                           s2_ready,
  input  logic signed [2*COORD_BITS+1:0] lhs_e,
  input  logic signed [2*COORD_BITS+1:0] rhs_e,
  input  logic signed [2*COORD_BITS+1:0] lhs_c,
  input  logic signed [2*COORD_BITS+1:0] rhs_c,
  input  logic signed [2*COORD_BITS+1:0] sq_x,
  input  logic signed [2*COORD_BITS+1:0] sq_y,
  input  pip_pkg::edge_t                 edges,
  input  pip_pkg::ctl_t                  ctl,
  pip_res_if.source                      res
);

  localparam int PW    = 2 * COORD_BITS + 2;
  localparam int DSW   = PW + 1;
  localparam int CMP_W = (DSW > pip_pkg::LIM_BITS) ? DSW : pip_pkg::LIM_BITS;

  logic [pip_pkg::LIM_BITS-1:0] lim;
  logic                         parity, near_seen;
  logic                         cross_e, cross_c, near_now;
  logic                         parity_next, near_next;
  logic [DSW-1:0]               dist_sq;
  logic                         out_free, fire;

  assign cfg.ready = 1'b1;

  // Squared slack, formed once per register write
  always_ff @(posedge clk) begin
    if (rst) begin
      lim <= pip_pkg::LIM_RESET;
    end else if (cfg.valid) begin
      lim <= pip_pkg::LIM_BITS'(cfg.slack) * pip_pkg::LIM_BITS'(cfg.slack);
    end
  end

  // Strict crossing compares, direction picks the operand order
  assign cross_e = ctl.has_prev && edges.str_e &&
                   (edges.pos_e ? (lhs_e < rhs_e) : (rhs_e < lhs_e));
  assign cross_c = ctl.last && edges.str_c &&
                   (edges.pos_c ? (lhs_c < rhs_c) : (rhs_c < lhs_c));

  // Squared distance against squared slack
  assign dist_sq  = DSW'($unsigned(sq_x)) + DSW'($unsigned(sq_y));
  assign near_now = (CMP_W'(dist_sq) <= CMP_W'(lim));

  assign parity_next = parity ^ cross_e ^ cross_c;
  assign near_next   = near_seen | near_now;

  // Only last-vertex beats need the result register
  assign out_free = !res.valid || res.ready;
  assign fire     = s2_valid && (!ctl.last || out_free);
  assign s2_ready = !s2_valid || fire;

  // Polygon state and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      parity    <= 1'b0;
      near_seen <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (fire && ctl.last) begin
        parity    <= 1'b0;
        near_seen <= 1'b0;
        res.valid <= 1'b1;
      end else begin
        if (fire) begin
          parity    <= parity_next;
          near_seen <= near_next;
        end
        if (res.ready) begin
          res.valid <= 1'b0;
        end
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (fire && ctl.last) begin
      res.inside_res  <= !ctl.few && parity_next;
      res.near_vertex <= !ctl.few && near_next;
      res.accepted    <= !ctl.few && (parity_next || near_next);
      res.too_few     <= ctl.few;
    end
  end

endmodule

// ===== sv/point_in_polygon_with_slack.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_with_slack
// Even-odd point-in-polygon test with a vertex proximity allowance.
// ----------------------------------------------------------------------------
// Usage:
//   vtx  - one beat per polygon vertex: query point, vertex, last_vertex.
//          The point is repeated for all vertices of one polygon.
//   res  - one beat per polygon, produced for the last_vertex beat:
//          accepted = inside_res | near_vertex; too_few forces all three to 0.
//   cfg  - slack write (always ready); write only while the block is idle.
// Pipeline: input register, product register (six multipliers), decide stage
//   with the result register. A last_vertex beat passes the input, product
//   and result registers before it shows on res. One vertex beat per cycle
//   outside stalls; the rate is set by the decide compare and parity update.
// Stall: a held result blocks only a further last_vertex beat at the decide
//   stage; a vertex beat is still taken into the input register only if it
//   is empty, then vtx.ready drops.
// Reset: slack returns to 2.0, all polygon state and valid flags clear.
// ----------------------------------------------------------------------------
module point_in_polygon_with_slack #(
  parameter int COORD_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  pip_vtx_if.sink   vtx,
  pip_res_if.source res,
  pip_cfg_if.sink   cfg
);

  localparam int PW = 2 * COORD_BITS + 2;

  logic                         s1_valid, s1_ready, s2_valid, s2_ready;
  logic signed [COORD_BITS-1:0] px, py, vx, vy, ax, ay, fx, fy;
  pip_pkg::ctl_t                ctl1, ctl2;
  pip_pkg::edge_t               edges;
  logic signed [PW-1:0]         lhs_e, rhs_e, lhs_c, rhs_c, sq_x, sq_y;

  pip_track #(.COORD_BITS(COORD_BITS)) u_track (
    .clk      (clk),
    .rst      (rst),
    .vtx      (vtx),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .px       (px),
    .py       (py),
    .vx       (vx),
    .vy       (vy),
    .ax       (ax),
    .ay       (ay),
    .fx       (fx),
    .fy       (fy),
    .ctl      (ctl1)
  );

  pip_geom #(.COORD_BITS(COORD_BITS)) u_geom (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .px       (px),
    .py       (py),
    .vx       (vx),
    .vy       (vy),
    .ax       (ax),
    .ay       (ay),
    .fx       (fx),
    .fy       (fy),
    .ctl_in   (ctl1),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .lhs_e    (lhs_e),
    .rhs_e    (rhs_e),
    .lhs_c    (lhs_c),
    .rhs_c    (rhs_c),
    .sq_x     (sq_x),
    .sq_y     (sq_y),
    .edges    (edges),
    .ctl_out  (ctl2)
  );

  pip_decide #(.COORD_BITS(COORD_BITS)) u_decide (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .lhs_e    (lhs_e),
    .rhs_e    (rhs_e),
    .lhs_c    (lhs_c),
    .rhs_c    (rhs_c),
    .sq_x     (sq_x),
    .sq_y     (sq_y),
    .edges    (edges),
    .ctl      (ctl2),
    .res      (res)
  );

endmodule

// ===== sv/pip_chk.sv =====
// ----------------------------------------------------------------------------
// pip_chk
// Port-level checks on the result channel of point_in_polygon_with_slack.
// ----------------------------------------------------------------------------
module pip_chk (
  input logic clk,
  input logic rst,
  input logic res_valid,
  input logic res_ready,
  input logic accepted,
  input logic inside_res,
  input logic near_vertex,
  input logic too_few
);

  // No result beat right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // Stalled result beat holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(accepted) &&
    $stable(inside_res) && $stable(near_vertex) && $stable(too_few))
    else $error("stalled result changed");

  // Verdict is the union of the crossing and proximity tests
  a_union: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> accepted == (inside_res || near_vertex))
    else $error("accepted mismatch");

  // Degenerate polygon gives a false verdict
  a_few: assert property (@(posedge clk) disable iff (rst)
    res_valid && too_few |-> !accepted && !inside_res && !near_vertex)
    else $error("too_few with nonzero verdict");

endmodule

bind point_in_polygon_with_slack pip_chk u_pip_chk (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .accepted    (res.accepted),
  .inside_res  (res.inside_res),
  .near_vertex (res.near_vertex),
  .too_few     (res.too_few)
);
